// ----- hw/rtl/tgi_pkg.sv -----
package tgi_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam logic [31:0] INV_SQRT_2PI = 32'd1713444047;
  localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
  localparam logic [63:0] CAP61 = 64'h2000_0000_0000_0000;
  localparam logic [63:0] CAP40 = 64'h0000_0100_0000_0000;
  localparam logic [63:0] CAP_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [4:0] TAYLOR_END = 5'd25;
  localparam logic [4:0] SQUARE_END = 5'd5;
  localparam logic [3:0] MAX_ITER_RST = 4'd10;
  localparam logic [31:0] TOL_RST = 32'd1;
  localparam logic CFG_MAX_ITER = 1'b0;
  localparam logic CFG_TOL = 1'b1;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP        = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD       = 5'd1;
  localparam logic [OP_W-1:0] OP_SQRT_START = 5'd2;
  localparam logic [OP_W-1:0] OP_SCALE_DIV  = 5'd3;
  localparam logic [OP_W-1:0] OP_SCALE_SET  = 5'd4;
  localparam logic [OP_W-1:0] OP_DIFF       = 5'd5;
  localparam logic [OP_W-1:0] OP_MUL_ADAD   = 5'd6;
  localparam logic [OP_W-1:0] OP_DIV_T      = 5'd7;
  localparam logic [OP_W-1:0] OP_EXP_INIT   = 5'd8;
  localparam logic [OP_W-1:0] OP_G_ZERO     = 5'd9;
  localparam logic [OP_W-1:0] OP_MUL_TERM   = 5'd10;
  localparam logic [OP_W-1:0] OP_DIV_K      = 5'd11;
  localparam logic [OP_W-1:0] OP_TERM_SET   = 5'd12;
  localparam logic [OP_W-1:0] OP_SQ_INIT    = 5'd13;
  localparam logic [OP_W-1:0] OP_MUL_EE     = 5'd14;
  localparam logic [OP_W-1:0] OP_E_SET      = 5'd15;
  localparam logic [OP_W-1:0] OP_MUL_SE     = 5'd16;
  localparam logic [OP_W-1:0] OP_GG_SET     = 5'd17;
  localparam logic [OP_W-1:0] OP_MUL_AG     = 5'd18;
  localparam logic [OP_W-1:0] OP_DIV_MAG    = 5'd19;
  localparam logic [OP_W-1:0] OP_G_SET      = 5'd20;
  localparam logic [OP_W-1:0] OP_FEVAL      = 5'd21;
  localparam logic [OP_W-1:0] OP_DIV_NEWTON = 5'd22;
  localparam logic [OP_W-1:0] OP_Z_SET      = 5'd23;
  localparam logic [OP_W-1:0] OP_DONE       = 5'd24;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            side;
    logic            conv;
  } cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic div_busy;
    logic sqrt_busy;
    logic t_big;
    logic taylor_done;
    logic sq_done;
    logic fp_zero;
    logic below_tol;
    logic at_max;
  } stat_t;

endpackage

// ----- hw/rtl/tgi_mul.sv -----
module tgi_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         busy,
  output logic [127:0] prod
);

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [1:0]   cnt;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  assign pp = (cnt[1] ? a_r[63:32] : a_r[31:0]) * (cnt[0] ? b_r[63:32] : b_r[31:0]);

  always_comb begin
    unique case (cnt)
      2'd0: pp_sh = {64'd0, pp};
      2'd3: pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= 2'd0;
    end else if (start) begin
      a_r <= a;
      b_r <= b;
      prod <= '0;
      cnt <= 2'd0;
      busy <= 1'b1;
    end else if (busy) begin
      prod <= prod + pp_sh;
      cnt <= cnt + 2'd1;
      if (cnt == 2'd3) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/tgi_div.sv -----
module tgi_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] num,
  input  logic [63:0]  den,
  input  logic [63:0]  cap,
  output logic         busy,
  output logic [63:0]  quo
);

  logic [63:0] rem;
  logic [63:0] lo;
  logic [63:0] q;
  logic [63:0] den_r;
  logic [63:0] cap_r;
  logic [5:0]  cnt;
  logic [63:0] r2;
  logic        take;
  logic [63:0] rem_n;
  logic [63:0] q_n;

  assign r2 = {rem[62:0], lo[63]};
  assign take = rem[63] || (r2 >= den_r);
  assign rem_n = take ? (r2 - den_r) : r2;
  assign q_n = {q[62:0], take};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= 6'd0;
    end else if (start) begin
      den_r <= den;
      cap_r <= cap;
      if ((den == 64'd0) || (num[127:64] >= den)) begin
        quo <= cap;
      end else begin
        rem <= num[127:64];
        lo <= num[63:0];
        q <= 64'd0;
        cnt <= 6'd0;
        busy <= 1'b1;
      end
    end else if (busy) begin
      rem <= rem_n;
      lo <= {lo[62:0], 1'b0};
      q <= q_n;
      cnt <= cnt + 6'd1;
      if (cnt == 6'd63) begin
        busy <= 1'b0;
        quo <= (q_n > cap_r) ? cap_r : q_n;
      end
    end
  end

endmodule

// ----- hw/rtl/tgi_sqrt.sv -----
module tgi_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x,
  output logic        busy,
  output logic [31:0] root
);

  logic [63:0] x_r;
  logic [63:0] r;
  logic [4:0]  i;
  logic [63:0] bit_v;
  logic [63:0] sum;

  assign bit_v = 64'd1 << {i, 1'b0};
  assign sum = r + bit_v;
  assign root = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      i <= 5'd0;
    end else if (start) begin
      x_r <= x;
      r <= 64'd0;
      i <= 5'd31;
      busy <= 1'b1;
    end else if (busy) begin
      if (x_r >= sum) begin
        x_r <= x_r - sum;
        r <= (r >> 1) + bit_v;
      end else begin
        r <= r >> 1;
      end
      i <= i - 5'd1;
      if (i == 5'd0) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/tgi_dp.sv -----
module tgi_dp #(
  parameter int FRAC_BITS = tgi_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  tgi_pkg::cmd_t       cmd,
  input  logic signed [31:0]  mean_first,
  input  logic [31:0]         variance_first,
  input  logic signed [31:0]  mean_second,
  input  logic [31:0]         variance_second,
  input  logic [3:0]          max_iterations,
  input  logic [31:0]         tolerance,
  output tgi_pkg::stat_t      stat,
  output logic signed [31:0]  crossing_point,
  output logic [3:0]          steps_used,
  output logic                converged
);

  import tgi_pkg::*;

  localparam int SH = 32 - (FRAC_BITS % 2);
  localparam int PW = (SH + FRAC_BITS) / 2;
  localparam int XSH = 57 - FRAC_BITS;
  localparam logic [63:0] TLIM = 64'd32 << FRAC_BITS;
  localparam logic [63:0] SCALE_NUM = {32'd0, INV_SQRT_2PI} << PW;

  logic signed [31:0] mlo, mhi, z;
  logic [31:0]        vlo, vhi;
  logic [63:0]        scl_lo, scl_hi;
  logic [32:0]        ad;
  logic               dpos;
  logic [63:0]        x, term, sum, e, gg;
  logic [4:0]         k;
  logic signed [63:0] g_lo, g_hi, gp_lo, gp_hi, f, fp;
  logic [3:0]         steps;

  logic         mul_start, mul_busy;
  logic [63:0]  mul_a, mul_b;
  logic [127:0] prod;
  logic         div_start, div_busy;
  logic [127:0] div_num;
  logic [63:0]  div_den, div_cap, quo;
  logic         sqrt_busy;
  logic [31:0]  root;

  logic signed [31:0] m_s;
  logic [31:0]        v_s;
  logic [63:0]        scl_s;
  logic [63:0]        mq62;
  logic signed [32:0] d;
  logic [63:0]        af, afp;
  logic signed [32:0] msum;
  logic signed [31:0] m1, m2;
  logic [31:0]        v1, v2;
  logic signed [41:0] zn;
  logic signed [31:0] zsat;

  assign m_s = cmd.side ? mhi : mlo;
  assign v_s = cmd.side ? vhi : vlo;
  assign scl_s = cmd.side ? scl_hi : scl_lo;
  assign mq62 = prod[125:62];
  assign d = {z[31], z} - {m_s[31], m_s};
  assign af = f[63] ? 64'(-f) : 64'(f);
  assign afp = fp[63] ? 64'(-fp) : 64'(fp);
  assign m1 = mean_first;
  assign m2 = mean_second;
  assign v1 = (variance_first == 32'd0) ? 32'd1 : variance_first;
  assign v2 = (variance_second == 32'd0) ? 32'd1 : variance_second;
  assign msum = {m1[31], m1} + {m2[31], m2};

  always_comb begin
    if (f[63] != fp[63]) begin
      zn = {{10{z[31]}}, z} + {1'b0, quo[40:0]};
    end else begin
      zn = {{10{z[31]}}, z} - {1'b0, quo[40:0]};
    end
    if (zn[41:31] != {11{zn[41]}}) begin
      zsat = zn[41] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      zsat = zn[31:0];
    end
  end

  always_comb begin
    mul_start = 1'b1;
    mul_a = 64'd0;
    mul_b = 64'd0;
    unique case (cmd.op)
      OP_MUL_ADAD: begin
        mul_a = {31'd0, ad};
        mul_b = {31'd0, ad};
      end
      OP_MUL_TERM: begin
        mul_a = term;
        mul_b = x;
      end
      OP_MUL_EE: begin
        mul_a = e;
        mul_b = e;
      end
      OP_MUL_SE: begin
        mul_a = scl_s;
        mul_b = e;
      end
      OP_MUL_AG: begin
        mul_a = {31'd0, ad};
        mul_b = gg;
      end
      default: mul_start = 1'b0;
    endcase
  end

  always_comb begin
    div_start = 1'b1;
    div_num = '0;
    div_den = 64'd0;
    div_cap = CAP_MAX;
    unique case (cmd.op)
      OP_SCALE_DIV: begin
        div_num = {64'd0, SCALE_NUM};
        div_den = (root == 32'd0) ? 64'd1 : {32'd0, root};
      end
      OP_DIV_T: begin
        div_num = prod;
        div_den = {31'd0, v_s, 1'b0};
        div_cap = TLIM;
      end
      OP_DIV_K: begin
        div_num = {64'd0, mq62};
        div_den = {59'd0, k};
      end
      OP_DIV_MAG: begin
        div_num = prod;
        div_den = {32'd0, v_s};
        div_cap = CAP61;
      end
      OP_DIV_NEWTON: begin
        div_num = {64'd0, af} << FRAC_BITS;
        div_den = afp;
        div_cap = CAP40;
      end
      default: div_start = 1'b0;
    endcase
  end

  tgi_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .prod  (prod)
  );

  tgi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .cap   (div_cap),
    .busy  (div_busy),
    .quo   (quo)
  );

  tgi_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == OP_SQRT_START),
    .x     ({32'd0, v_s} << SH),
    .busy  (sqrt_busy),
    .root  (root)
  );

  always_comb begin
    stat.mul_busy = mul_busy;
    stat.div_busy = div_busy;
    stat.sqrt_busy = sqrt_busy;
    stat.t_big = quo >= TLIM;
    stat.taylor_done = k == TAYLOR_END;
    stat.sq_done = k == SQUARE_END;
    stat.fp_zero = fp == 64'sd0;
    stat.below_tol = af < {32'd0, tolerance};
    stat.at_max = steps >= max_iterations;
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        if (m1 <= m2) begin
          mlo <= m1;
          vlo <= v1;
          mhi <= m2;
          vhi <= v2;
        end else begin
          mlo <= m2;
          vlo <= v2;
          mhi <= m1;
          vhi <= v1;
        end
        z <= 32'((msum + {32'd0, msum[32]}) >>> 1);
        steps <= 4'd0;
      end
      OP_SCALE_SET: begin
        if (cmd.side) begin
          scl_hi <= quo;
        end else begin
          scl_lo <= quo;
        end
      end
      OP_DIFF: begin
        ad <= d[32] ? 33'(-d) : 33'(d);
        dpos <= !d[32] && (d != 33'sd0);
      end
      OP_EXP_INIT: begin
        x <= quo << XSH;
        term <= ONE_Q62;
        sum <= ONE_Q62;
        k <= 5'd1;
      end
      OP_G_ZERO: begin
        if (cmd.side) begin
          g_hi <= 64'sd0;
          gp_hi <= 64'sd0;
        end else begin
          g_lo <= 64'sd0;
          gp_lo <= 64'sd0;
        end
      end
      OP_TERM_SET: begin
        term <= quo;
        if (k[0]) begin
          sum <= (quo > sum) ? 64'd0 : sum - quo;
        end else begin
          sum <= sum + quo;
        end
        k <= k + 5'd1;
      end
      OP_SQ_INIT: begin
        e <= sum;
        k <= 5'd0;
      end
      OP_E_SET: begin
        e <= mq62;
        k <= k + 5'd1;
      end
      OP_GG_SET: gg <= mq62;
      OP_G_SET: begin
        if (cmd.side) begin
          g_hi <= gg;
          gp_hi <= dpos ? -$signed(quo) : $signed(quo);
        end else begin
          g_lo <= gg;
          gp_lo <= dpos ? -$signed(quo) : $signed(quo);
        end
      end
      OP_FEVAL: begin
        f <= g_hi - g_lo;
        fp <= gp_hi - gp_lo;
      end
      OP_Z_SET: begin
        z <= zsat;
        steps <= steps + 4'd1;
      end
      OP_DONE: begin
        crossing_point <= z;
        steps_used <= steps;
        converged <= cmd.conv;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/tgi_ctrl.sv -----
module tgi_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  tgi_pkg::stat_t stat,
  output tgi_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           done
);

  import tgi_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SC_SQ = 5'd1;
  localparam logic [4:0] S_SC_SQW = 5'd2;
  localparam logic [4:0] S_SC_DVW = 5'd3;
  localparam logic [4:0] S_DIFF  = 5'd4;
  localparam logic [4:0] S_AD    = 5'd5;
  localparam logic [4:0] S_ADW   = 5'd6;
  localparam logic [4:0] S_TW    = 5'd7;
  localparam logic [4:0] S_TCHK  = 5'd8;
  localparam logic [4:0] S_TMW   = 5'd9;
  localparam logic [4:0] S_TDW   = 5'd10;
  localparam logic [4:0] S_TNEXT = 5'd11;
  localparam logic [4:0] S_SQ    = 5'd12;
  localparam logic [4:0] S_SQW   = 5'd13;
  localparam logic [4:0] S_SQCHK = 5'd14;
  localparam logic [4:0] S_SEW   = 5'd15;
  localparam logic [4:0] S_AG    = 5'd16;
  localparam logic [4:0] S_AGW   = 5'd17;
  localparam logic [4:0] S_MAGW  = 5'd18;
  localparam logic [4:0] S_NEXT  = 5'd19;
  localparam logic [4:0] S_EVAL  = 5'd20;
  localparam logic [4:0] S_CHK   = 5'd21;
  localparam logic [4:0] S_NWW   = 5'd22;

  logic [4:0] state, state_next;
  logic       side, side_next;
  logic       phase, phase_next;

  assign busy = state != S_IDLE;

  always_comb begin
    state_next = state;
    side_next = side;
    phase_next = phase;
    cmd.op = OP_NOP;
    cmd.side = side;
    cmd.conv = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
          side_next = 1'b0;
          phase_next = 1'b0;
          state_next = S_SC_SQ;
        end
      end
      S_SC_SQ: begin
        cmd.op = OP_SQRT_START;
        state_next = S_SC_SQW;
      end
      S_SC_SQW: begin
        if (!stat.sqrt_busy) begin
          cmd.op = OP_SCALE_DIV;
          state_next = S_SC_DVW;
        end
      end
      S_SC_DVW: begin
        if (!stat.div_busy) begin
          cmd.op = OP_SCALE_SET;
          side_next = !side;
          state_next = side ? S_DIFF : S_SC_SQ;
        end
      end
      S_DIFF: begin
        cmd.op = OP_DIFF;
        state_next = S_AD;
      end
      S_AD: begin
        cmd.op = OP_MUL_ADAD;
        state_next = S_ADW;
      end
      S_ADW: begin
        if (!stat.mul_busy) begin
          cmd.op = OP_DIV_T;
          state_next = S_TW;
        end
      end
      S_TW: begin
        if (!stat.div_busy) begin
          cmd.op = OP_EXP_INIT;
          state_next = S_TCHK;
        end
      end
      S_TCHK: begin
        if (stat.t_big) begin
          cmd.op = OP_G_ZERO;
          state_next = S_NEXT;
        end else begin
          cmd.op = OP_MUL_TERM;
          state_next = S_TMW;
        end
      end
      S_TMW: begin
        if (!stat.mul_busy) begin
          cmd.op = OP_DIV_K;
          state_next = S_TDW;
        end
      end
      S_TDW: begin
        if (!stat.div_busy) begin
          cmd.op = OP_TERM_SET;
          state_next = S_TNEXT;
        end
      end
      S_TNEXT: begin
        if (stat.taylor_done) begin
          cmd.op = OP_SQ_INIT;
          state_next = S_SQ;
        end else begin
          cmd.op = OP_MUL_TERM;
          state_next = S_TMW;
        end
      end
      S_SQ: begin
        cmd.op = OP_MUL_EE;
        state_next = S_SQW;
      end
      S_SQW: begin
        if (!stat.mul_busy) begin
          cmd.op = OP_E_SET;
          state_next = S_SQCHK;
        end
      end
      S_SQCHK: begin
        if (stat.sq_done) begin
          cmd.op = OP_MUL_SE;
          state_next = S_SEW;
        end else begin
          cmd.op = OP_MUL_EE;
          state_next = S_SQW;
        end
      end
      S_SEW: begin
        if (!stat.mul_busy) begin
          cmd.op = OP_GG_SET;
          state_next = S_AG;
        end
      end
      S_AG: begin
        cmd.op = OP_MUL_AG;
        state_next = S_AGW;
      end
      S_AGW: begin
        if (!stat.mul_busy) begin
          cmd.op = OP_DIV_MAG;
          state_next = S_MAGW;
        end
      end
      S_MAGW: begin
        if (!stat.div_busy) begin
          cmd.op = OP_G_SET;
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        side_next = 1'b1;
        state_next = side ? S_EVAL : S_DIFF;
      end
      S_EVAL: begin
        cmd.op = OP_FEVAL;
        state_next = S_CHK;
      end
      S_CHK: begin
        priority if (phase && stat.below_tol) begin
          cmd.op = OP_DONE;
          cmd.conv = 1'b1;
          state_next = S_IDLE;
        end else if (stat.at_max || stat.fp_zero) begin
          cmd.op = OP_DONE;
          state_next = S_IDLE;
        end else begin
          cmd.op = OP_DIV_NEWTON;
          state_next = S_NWW;
        end
      end
      S_NWW: begin
        if (!stat.div_busy) begin
          cmd.op = OP_Z_SET;
          side_next = 1'b0;
          phase_next = 1'b1;
          state_next = S_DIFF;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      side <= 1'b0;
      phase <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      side <= side_next;
      phase <= phase_next;
      done <= cmd.op == OP_DONE;
    end
  end

endmodule

// ----- hw/rtl/two_gaussian_intersection.sv -----
// channel   ports                                              handshake
// request   start, mean_first, variance_first, mean_second,    start & !busy
//           variance_second
// result    done, crossing_point, steps_used, converged        done, one cycle
// config    cfg_valid, cfg_ready, cfg_index, cfg_data          cfg_valid & cfg_ready
//
// One request at a time. Scale setup (a square root and a division per side) runs
// first; each evaluation of the two densities is run (steps_used + 1) times, with
// one division per Newton step in between. The bit-serial divider is shared and is
// used 26 times per density; a density whose exponent is out of range skips the
// series and is set to zero.
// Reset clears the controller and loads max_iterations = 10, tolerance = 1.
// Results cannot be stalled; done pulses with the result for one cycle.
module two_gaussian_intersection #(
  parameter int FRAC_BITS = tgi_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] mean_first,
  input  logic [31:0]        variance_first,
  input  logic signed [31:0] mean_second,
  input  logic [31:0]        variance_second,
  output logic               done,
  output logic signed [31:0] crossing_point,
  output logic [3:0]         steps_used,
  output logic               converged,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  import tgi_pkg::*;

  logic [3:0]  max_iterations;
  logic [31:0] tolerance;
  cmd_t        cmd;
  stat_t       stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= MAX_ITER_RST;
      tolerance <= TOL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_ITER: max_iterations <= cfg_data[3:0];
        CFG_TOL: tolerance <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tgi_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  tgi_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .mean_first      (mean_first),
    .variance_first  (variance_first),
    .mean_second     (mean_second),
    .variance_second (variance_second),
    .max_iterations  (max_iterations),
    .tolerance       (tolerance),
    .stat            (stat),
    .crossing_point  (crossing_point),
    .steps_used      (steps_used),
    .converged       (converged)
  );

endmodule

// ----- bench/two_gaussian_intersection_tb.sv -----
module two_gaussian_intersection_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tgi_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int STALL_LIMIT = 400000;

  typedef struct {
    logic signed [31:0] point;
    logic [3:0]         steps;
    logic               conv;
  } crossing_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] mean_first = '0;
  logic [31:0]        variance_first = 32'd1;
  logic signed [31:0] mean_second = '0;
  logic [31:0]        variance_second = 32'd1;
  logic               done;
  logic signed [31:0] crossing_point;
  logic [3:0]         steps_used;
  logic               converged;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = CFG_MAX_ITER;
  logic [31:0]        cfg_data = '0;

  crossing_t   crossings_due[$];
  logic [3:0]  iter_limit;
  logic [31:0] diff_tol;
  int          errors = 0;
  int          requests_sent = 0;
  int          results_seen = 0;
  int          converged_seen = 0;
  int          stall_cycles = 0;
  bit          idle_on = 1'b1;

  two_gaussian_intersection dut (
    .clk, .rst, .start, .busy, .mean_first, .variance_first, .mean_second,
    .variance_second, .done, .crossing_point, .steps_used, .converged,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic logic [63:0] capped_div(logic [127:0] n, logic [63:0] d,
                                             logic [63:0] cap);
    logic [127:0] q;
    if (d == 0 || n[127:64] >= d) return cap;
    q = n / {64'd0, d};
    return (q[63:0] > cap) ? cap : q[63:0];
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] exp_series(logic [63:0] x);
    logic [63:0] term, sum;
    term = ONE_Q62;
    sum = ONE_Q62;
    for (int k = 1; k <= 24; k++) begin
      term = q62_mul(term, x) / 64'(k);
      if (k % 2 == 1) sum = (term > sum) ? 64'd0 : sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  task automatic gauss_eval(input longint z, input longint m, input logic [63:0] v,
                            output longint g, output longint gp);
    longint      d;
    logic [63:0] ad, t, e, sq, scale, gg, mag, tlim;
    int          sh, p;
    d = z - m;
    ad = (d < 0) ? unsigned'(-d) : unsigned'(d);
    tlim = 64'd32 << FB;
    t = capped_div({64'd0, ad} * {64'd0, ad}, v << 1, tlim);
    if (t >= tlim) begin
      g = 0;
      gp = 0;
    end else begin
      e = exp_series(t << (57 - FB));
      repeat (5) e = q62_mul(e, e);
      sh = 32 - (FB % 2);
      p = (sh + FB) / 2;
      sq = root_floor(v << sh);
      if (sq == 0) sq = 1;
      scale = ({32'd0, INV_SQRT_2PI} << p) / sq;
      gg = q62_mul(scale, e);
      mag = capped_div({64'd0, ad} * {64'd0, gg}, v, CAP61);
      g = signed'(gg);
      gp = (d > 0) ? -signed'(mag) : signed'(mag);
    end
  endtask

  task automatic predict_crossing(input logic signed [31:0] m1_in, input logic [31:0] v1_in,
                                  input logic signed [31:0] m2_in, input logic [31:0] v2_in,
                                  output crossing_t res);
    longint      m1, m2, mlo, mhi, z, glo, glop, ghi, ghip, f, fp;
    logic [63:0] v1, v2, vlo, vhi, af, afp, q;
    int          steps;
    m1 = m1_in;
    m2 = m2_in;
    v1 = (v1_in == 0) ? 64'd1 : {32'd0, v1_in};
    v2 = (v2_in == 0) ? 64'd1 : {32'd0, v2_in};
    if (m1 <= m2) begin
      mlo = m1; vlo = v1; mhi = m2; vhi = v2;
    end else begin
      mlo = m2; vlo = v2; mhi = m1; vhi = v1;
    end
    res.conv = 1'b0;
    steps = 0;
    z = (m1 + m2) / 2;
    gauss_eval(z, mlo, vlo, glo, glop);
    gauss_eval(z, mhi, vhi, ghi, ghip);
    f = ghi - glo;
    fp = ghip - glop;
    while (steps < iter_limit) begin
      if (fp == 0) break;
      af = (f < 0) ? unsigned'(-f) : unsigned'(f);
      afp = (fp < 0) ? unsigned'(-fp) : unsigned'(fp);
      q = capped_div({64'd0, af} << FB, afp, CAP40);
      z = ((f < 0) != (fp < 0)) ? z + signed'(q) : z - signed'(q);
      if (z > 64'sd2147483647) z = 64'sd2147483647;
      if (z < -64'sd2147483648) z = -64'sd2147483648;
      steps++;
      gauss_eval(z, mlo, vlo, glo, glop);
      gauss_eval(z, mhi, vhi, ghi, ghip);
      f = ghi - glo;
      fp = ghip - glop;
      af = (f < 0) ? unsigned'(-f) : unsigned'(f);
      if (af < {32'd0, diff_tol}) begin
        res.conv = 1'b1;
        break;
      end
    end
    res.point = z[31:0];
    res.steps = steps[3:0];
  endtask

  task automatic send_request(input logic signed [31:0] m1, input logic [31:0] v1,
                              input logic signed [31:0] m2, input logic [31:0] v2);
    crossing_t res;
    @(posedge clk);
    while (idle_on && $urandom_range(99) < 23) @(posedge clk);
    start <= 1'b1;
    mean_first <= m1;
    variance_first <= v1;
    mean_second <= m2;
    variance_second <= v2;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    predict_crossing(m1, v1, m2, v2, res);
    crossings_due.insert(crossings_due.size(), res);
    requests_sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    wait (crossings_due.size() == 0);
    repeat (8000) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_MAX_ITER) iter_limit = data[3:0];
    else diff_tol = data;
  endtask

  always @(posedge clk) begin
    crossing_t want;
    if (!rst && done) begin
      results_seen++;
      if (converged) converged_seen++;
      if (crossings_due.size() == 0) begin
        $display("%0t: unexpected result point=%h steps=%0d conv=%b", $time,
                 crossing_point, steps_used, converged);
        errors++;
      end else begin
        want = crossings_due.pop_front();
        if (crossing_point !== want.point) begin
          $display("%0t: crossing_point expected %h actual %h", $time, want.point,
                   crossing_point);
          errors++;
        end
        if (steps_used !== want.steps) begin
          $display("%0t: steps_used expected %0d actual %0d", $time, want.steps,
                   steps_used);
          errors++;
        end
        if (converged !== want.conv) begin
          $display("%0t: converged expected %b actual %b", $time, want.conv, converged);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("two_gaussian_intersection_tb: done, errors");
        $finish;
      end
    end
  end

  function automatic logic [31:0] near_variance();
    return 32'($urandom_range(32'h0400_0000, 32'h0040_0000));
  endfunction

  function automatic logic signed [31:0] near_mean();
    return 32'(signed'($urandom_range(32'h0800_0000)) - 32'sh0400_0000);
  endfunction

  task automatic test_directed();
    idle_on = 1'b0;
    send_request(32'sh0100_0000, 32'h0100_0000, 32'sh0100_0000, 32'h0100_0000);
    send_request(32'sh0000_0000, 32'h0100_0000, 32'sh0200_0000, 32'h0400_0000);
    send_request(32'sh0200_0000, 32'h0400_0000, 32'sh0000_0000, 32'h0100_0000);
    send_request(32'sh8000_0000, 32'h0000_0001, 32'sh7FFF_FFFF, 32'h0000_0001);
    send_request(32'sh7FFF_FFFF, 32'hFFFF_FFFF, 32'sh8000_0000, 32'hFFFF_FFFF);
    send_request(32'sh0000_0000, 32'h0000_0000, 32'sh0000_0010, 32'h0000_0000);
    send_request(-32'sh0080_0000, 32'h0000_0000, 32'sh0080_0000, 32'h0200_0000);
    send_request(32'sh8000_0000, 32'h0100_0000, 32'sh8000_0000, 32'h0100_0000);
    send_request(32'sh7FFF_FFFF, 32'h0100_0000, 32'sh7FFF_0000, 32'hFFFF_FFFF);
    send_request(32'sh0000_0000, 32'h0010_0000, 32'sh0100_0000, 32'h0800_0000);
    idle_on = 1'b1;
    write_reg(CFG_MAX_ITER, 32'd15);
    write_reg(CFG_TOL, 32'd0);
    send_request(32'sh0000_0000, 32'h0100_0000, 32'sh0180_0000, 32'h0300_0000);
    send_request(-32'sh0200_0000, 32'h0080_0000, 32'sh0100_0000, 32'h0200_0000);
    write_reg(CFG_TOL, 32'hFFFF_FFFF);
    send_request(32'sh0000_0000, 32'h0100_0000, 32'sh0180_0000, 32'h0300_0000);
    send_request(32'sh0000_0000, 32'h0100_0000, 32'sh0000_0000, 32'h0100_0000);
    write_reg(CFG_MAX_ITER, 32'd0);
    send_request(32'sh0000_0000, 32'h0100_0000, 32'sh0180_0000, 32'h0300_0000);
    send_request(32'sh7FFF_FFFF, 32'h0100_0000, -32'sh0000_0003, 32'h0300_0000);
    write_reg(CFG_MAX_ITER, 32'd1);
    write_reg(CFG_TOL, 32'h0001_0000);
    send_request(32'sh0000_0000, 32'h0100_0000, 32'sh0180_0000, 32'h0300_0000);
    send_request(32'sh0040_0000, 32'h0200_0000, -32'sh0100_0000, 32'h0080_0000);
  endtask

  task automatic test_random();
    logic [31:0] tol;
    for (int phase = 0; phase < 9; phase++) begin
      write_reg(CFG_MAX_ITER, (phase == 8) ? 32'd15 : 32'($urandom_range(4, 1)));
      case ($urandom_range(3))
        0: tol = 32'd0;
        1: tol = $urandom;
        default: tol = 32'($urandom_range(32'h0010_0000, 32'h0000_0100));
      endcase
      write_reg(CFG_TOL, tol);
      idle_on = (phase != 3);
      repeat ((phase == 8) ? 10 : 55) begin
        if ($urandom_range(99) < 80)
          send_request(near_mean(), near_variance(), near_mean(), near_variance());
        else
          send_request($urandom, $urandom, $urandom, $urandom);
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    iter_limit = MAX_ITER_RST;
    diff_tol = TOL_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    wait (crossings_due.size() == 0);
    repeat (200) @(posedge clk);
    $display("covered %0d requests, %0d results, %0d converged", requests_sent,
             results_seen, converged_seen);
    $display("step limits 0..15 and tolerance 0..max, equal, reversed and extreme means");
    if (errors == 0) begin
      $display("two_gaussian_intersection_tb: done, clean");
    end else begin
      $display("two_gaussian_intersection_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- two_gaussian_intersection.f -----
hw/rtl/tgi_pkg.sv
hw/rtl/tgi_mul.sv
hw/rtl/tgi_div.sv
hw/rtl/tgi_sqrt.sv
hw/rtl/tgi_dp.sv
hw/rtl/tgi_ctrl.sv
hw/rtl/two_gaussian_intersection.sv
bench/two_gaussian_intersection_tb.sv
